[rtl/sacl_pkg.sv]
// Package for the set-associative LRU write-back cache tag store.
package sacl_pkg;

  localparam int unsigned WAYS_DEF = 4;
  localparam int unsigned SETS_DEF = 64;
  localparam int unsigned ADDR_W   = 32;
  localparam int unsigned CNT_W    = 32;

  // Register indexes
  localparam logic [1:0] REG_OFFSET_BITS = 2'd0;
  localparam logic [1:0] REG_INDEX_BITS  = 2'd1;
  localparam logic [1:0] REG_WAYS_IN_USE = 2'd2;

  // Access kinds
  localparam logic ACT_READ  = 1'b0;
  localparam logic ACT_WRITE = 1'b1;

  typedef struct packed {
    logic              action;
    logic [ADDR_W-1:0] address;
  } sacl_in_t;

  typedef struct packed {
    logic             hit;
    logic             write_back;
    logic [1:0]       way_used;
    logic [CNT_W-1:0] read_total;
    logic [CNT_W-1:0] write_total;
    logic [CNT_W-1:0] read_hit_total;
    logic [CNT_W-1:0] write_hit_total;
    logic [CNT_W-1:0] read_miss_total;
    logic [CNT_W-1:0] write_miss_total;
    logic [CNT_W-1:0] write_back_total;
  } sacl_out_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP
  } sacl_state_t;

endpackage

[rtl/set_assoc_cache_lru_writeback.sv]
// Top level: set-associative write-back cache tag store with true-LRU replacement.
// Flow: an accepted word is latched with its set row, looked up, and its result
// registered at the end of lookup. No access is taken while one is in lookup, since
// the set memory is read then written back (one read-modify-write per access), nor
// while a result waits for the receiver. Reset: counters clear and registers return
// to defaults, then a clearing pass marks every set invalid before any access is taken.
module set_assoc_cache_lru_writeback
  import sacl_pkg::*;
#(
  parameter int unsigned WAYS = WAYS_DEF,
  parameter int unsigned SETS = SETS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  sacl_in_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output sacl_out_t out_data,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [2:0] cfg_data
);

  localparam int unsigned SW = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int unsigned WW = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int unsigned RW = WW;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic              valid;
    logic              dirty;
    logic [RW-1:0]     rank;
  } way_t;

  typedef way_t [WAYS-1:0] set_row_t;

  // Set memory: one row per set
  set_row_t mem [SETS];
  set_row_t rd_row;

  sacl_state_t state_r, state_nxt;
  logic [SW-1:0] clr_ptr_r;
  logic [2:0] offset_bits_r, index_bits_r, ways_in_use_r;
  sacl_in_t req_r;
  logic [SW-1:0] set_r;
  logic [CNT_W-1:0] stat_r [7];
  logic out_valid_r;
  sacl_out_t out_r;

  // Configuration
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_bits_r <= 3'd4;
      index_bits_r  <= 3'd2;
      ways_in_use_r <= 3'd2;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_OFFSET_BITS: offset_bits_r <= cfg_data;
        REG_INDEX_BITS:  index_bits_r  <= cfg_data;
        REG_WAYS_IN_USE: ways_in_use_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Set index of the incoming word
  logic [2:0] ob_in;
  logic [ADDR_W-1:0] sh_in, imask;
  logic [SW-1:0] set_in;
  always_comb begin
    ob_in = (offset_bits_r < 3'd2) ? 3'd2 : ((offset_bits_r > 3'd5) ? 3'd5 : offset_bits_r);
    sh_in = in_data.address >> ob_in;
    imask = (ADDR_W'(1) << index_bits_r) - ADDR_W'(1);
    set_in = SW'((sh_in & imask) % SETS);
  end

  assign in_ready = (state_r == ST_IDLE) && (!out_valid_r || out_ready);
  logic in_acc;
  assign in_acc = in_valid && in_ready;

  always_comb begin
    unique case (state_r)
      ST_CLEAR:  state_nxt = (clr_ptr_r == SW'(SETS - 1)) ? ST_IDLE : ST_CLEAR;
      ST_IDLE:   state_nxt = in_acc ? ST_LOOKUP : ST_IDLE;
      ST_LOOKUP: state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      clr_ptr_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) clr_ptr_r <= clr_ptr_r + SW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      req_r <= in_data;
      set_r <= set_in;
    end
  end

  // Lookup, victim choice and LRU update on the row read back
  logic [2:0] ob, nw;
  logic [ADDR_W-1:0] tagline;
  logic hit, found_free, wb, is_wr;
  logic [WW-1:0] used;
  logic [RW-1:0] best, old_rank;
  logic [RW:0] others;
  set_row_t new_row;
  always_comb begin
    ob = (offset_bits_r < 3'd2) ? 3'd2 : ((offset_bits_r > 3'd5) ? 3'd5 : offset_bits_r);
    nw = (ways_in_use_r < 3'd1) ? 3'd1 :
         ((32'(ways_in_use_r) > WAYS) ? 3'(WAYS) : ways_in_use_r);
    tagline = req_r.address & ~((ADDR_W'(1) << ob) - ADDR_W'(1));
    is_wr = (req_r.action == ACT_WRITE);
    hit = 1'b0;
    used = '0;
    for (int k = WAYS - 1; k >= 0; k--) begin
      if (k < 32'(nw) && rd_row[k].valid && rd_row[k].addr == tagline) begin
        hit = 1'b1;
        used = WW'(k);
      end
    end
    found_free = 1'b0;
    best = '0;
    if (!hit) begin
      for (int k = 0; k < WAYS; k++) begin
        if (k < 32'(nw) && !found_free) begin
          if (!rd_row[k].valid) begin
            found_free = 1'b1;
            used = WW'(k);
          end else if (k == 0 || rd_row[k].rank < best) begin
            best = rd_row[k].rank;
            used = WW'(k);
          end
        end
      end
    end
    wb = !hit && !found_free && rd_row[used].dirty;
    // touch: demote ways above the used one, used becomes newest
    old_rank = rd_row[used].rank;
    others = '0;
    new_row = rd_row;
    for (int k = 0; k < WAYS; k++) begin
      if (WW'(k) != used && rd_row[k].valid) begin
        others = others + (RW+1)'(1);
        if (rd_row[used].valid && rd_row[k].rank > old_rank)
          new_row[k].rank = rd_row[k].rank - RW'(1);
      end
    end
    new_row[used].rank = others[RW-1:0];
    if (hit) begin
      if (is_wr) new_row[used].dirty = 1'b1;
    end else begin
      new_row[used].valid = 1'b1;
      new_row[used].addr  = tagline;
      new_row[used].dirty = is_wr;
    end
  end

  // Memory: clear sweep, read on accept, write back in lookup
  always_ff @(posedge clk) begin
    if (state_r == ST_CLEAR) mem[clr_ptr_r] <= '0;
    else if (state_r == ST_LOOKUP) mem[set_r] <= new_row;
    if (in_acc) rd_row <= mem[set_in];
  end

  // Statistics counters and result register
  logic [CNT_W-1:0] s_nxt [7];
  always_comb begin
    for (int i = 0; i < 7; i++) s_nxt[i] = stat_r[i];
    if (is_wr) s_nxt[1] = stat_r[1] + CNT_W'(1);
    else       s_nxt[0] = stat_r[0] + CNT_W'(1);
    if (hit && is_wr)   s_nxt[3] = stat_r[3] + CNT_W'(1);
    if (hit && !is_wr)  s_nxt[2] = stat_r[2] + CNT_W'(1);
    if (!hit && is_wr)  s_nxt[5] = stat_r[5] + CNT_W'(1);
    if (!hit && !is_wr) s_nxt[4] = stat_r[4] + CNT_W'(1);
    if (wb)             s_nxt[6] = stat_r[6] + CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 7; i++) stat_r[i] <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (state_r == ST_LOOKUP) begin
        for (int i = 0; i < 7; i++) stat_r[i] <= s_nxt[i];
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_LOOKUP) begin
      out_r.hit              <= hit;
      out_r.write_back       <= wb;
      out_r.way_used         <= 2'(used);
      out_r.read_total       <= s_nxt[0];
      out_r.write_total      <= s_nxt[1];
      out_r.read_hit_total   <= s_nxt[2];
      out_r.write_hit_total  <= s_nxt[3];
      out_r.read_miss_total  <= s_nxt[4];
      out_r.write_miss_total <= s_nxt[5];
      out_r.write_back_total <= s_nxt[6];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Checks
  a_hit_no_wb: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) && out_data.hit |-> !out_data.write_back)
    else $error("write-back flagged on a hit");
  a_lookup_follows_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> state_r == ST_LOOKUP)
    else $error("accepted word not looked up");
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_CLEAR |-> !in_ready)
    else $error("word accepted during clearing pass");

endmodule

[verif/tb_set_assoc_cache_lru_writeback.sv]
// Testbench for the set-associative LRU write-back cache tag store.
`timescale 1ns / 1ps

module tb_set_assoc_cache_lru_writeback;
  import sacl_pkg::*;

  localparam int unsigned NWAYS = 4;
  localparam int unsigned NSETS = 64;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned DRAIN_CYCLES = 8;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  sacl_in_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  sacl_out_t out_data;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [2:0] cfg_data = '0;

  // Tag store shadow and configuration copy
  logic [31:0] tag_line [NSETS][NWAYS];
  logic        tag_valid [NSETS][NWAYS];
  logic        tag_dirty [NSETS][NWAYS];
  int unsigned age_rank [NSETS][NWAYS];
  logic [31:0] cnt_read, cnt_write, cnt_rhit, cnt_whit, cnt_rmiss, cnt_wmiss, cnt_wb;
  logic [2:0]  sh_offset, sh_index, sh_ways;

  sacl_out_t   pending_results[$];
  int unsigned send_idle_pct, recv_idle_pct;
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;

  set_assoc_cache_lru_writeback u_dut (.*);

  // Clock, period 4 ns
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Receiver stall
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Result checker
  always @(posedge clk) begin
    sacl_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected word %h", $time, out_data);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (want.hit !== out_data.hit ||
            want.write_back !== out_data.write_back ||
            want.way_used !== out_data.way_used ||
            want.read_total !== out_data.read_total ||
            want.write_total !== out_data.write_total ||
            want.read_hit_total !== out_data.read_hit_total ||
            want.write_hit_total !== out_data.write_hit_total ||
            want.read_miss_total !== out_data.read_miss_total ||
            want.write_miss_total !== out_data.write_miss_total ||
            want.write_back_total !== out_data.write_back_total) begin
          $display("%0t: mismatch expected %h actual %h", $time, want, out_data);
          error_count++;
        end
      end
    end
  end

  // Move way w of set s to most recent among valid ways
  function automatic void promote_way(int unsigned s, int unsigned w);
    int unsigned others;
    others = 0;
    for (int unsigned k = 0; k < NWAYS; k++) begin
      if (k != w && tag_valid[s][k]) begin
        others++;
        if (tag_valid[s][w] && age_rank[s][k] > age_rank[s][w])
          age_rank[s][k]--;
      end
    end
    age_rank[s][w] = others;
  endfunction

  // Predict the result of one access and update the shadow
  function automatic sacl_out_t predict_access(sacl_in_t acc);
    sacl_out_t   r;
    int unsigned ob, nw, s, used, best;
    logic [31:0] line, imask;
    logic        hit, wb, free;
    ob = (sh_offset < 2) ? 2 : ((sh_offset > 5) ? 5 : sh_offset);
    nw = (sh_ways < 1) ? 1 : ((sh_ways > NWAYS) ? NWAYS : sh_ways);
    imask = (32'd1 << sh_index) - 32'd1;
    s = ((acc.address >> ob) & imask) % NSETS;
    line = acc.address & ~((32'd1 << ob) - 32'd1);
    hit = 1'b0;
    wb = 1'b0;
    used = 0;
    if (acc.action == ACT_WRITE) cnt_write++; else cnt_read++;
    for (int unsigned k = 0; k < nw; k++) begin
      if (!hit && tag_valid[s][k] && tag_line[s][k] == line) begin
        hit = 1'b1;
        used = k;
      end
    end
    if (hit) begin
      promote_way(s, used);
      if (acc.action == ACT_WRITE) begin
        tag_dirty[s][used] = 1'b1;
        cnt_whit++;
      end else begin
        cnt_rhit++;
      end
    end else begin
      free = 1'b0;
      best = 0;
      for (int unsigned k = 0; k < nw; k++) begin
        if (!free) begin
          if (!tag_valid[s][k]) begin
            free = 1'b1;
            used = k;
          end else if (k == 0 || age_rank[s][k] < best) begin
            best = age_rank[s][k];
            used = k;
          end
        end
      end
      if (!free && tag_dirty[s][used]) begin
        wb = 1'b1;
        cnt_wb++;
      end
      promote_way(s, used);
      tag_valid[s][used] = 1'b1;
      tag_line[s][used] = line;
      tag_dirty[s][used] = acc.action;
      if (acc.action == ACT_WRITE) cnt_wmiss++; else cnt_rmiss++;
    end
    r.hit = hit;
    r.write_back = wb;
    r.way_used = used[1:0];
    r.read_total = cnt_read;
    r.write_total = cnt_write;
    r.read_hit_total = cnt_rhit;
    r.write_hit_total = cnt_whit;
    r.read_miss_total = cnt_rmiss;
    r.write_miss_total = cnt_wmiss;
    r.write_back_total = cnt_wb;
    return r;
  endfunction

  // Send one access word, with random sender gaps
  task automatic send_access(logic act, logic [31:0] addr);
    sacl_in_t w;
    while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    w.action = act;
    w.address = addr;
    in_valid <= 1'b1;
    in_data <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_results.push_back(predict_access(w));
    in_valid <= 1'b0;
    // the block is in lookup for this cycle and cannot take another word
    @(posedge clk);
  endtask

  task automatic wait_drained();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Register write; only called with the block idle
  task automatic write_reg(logic [1:0] idx, logic [2:0] val);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == REG_OFFSET_BITS) sh_offset = val;
    else if (idx == REG_INDEX_BITS) sh_index = val;
    else if (idx == REG_WAYS_IN_USE) sh_ways = val;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_geometry(logic [2:0] ob, logic [2:0] ib, logic [2:0] nw);
    write_reg(REG_OFFSET_BITS, ob);
    write_reg(REG_INDEX_BITS, ib);
    write_reg(REG_WAYS_IN_USE, nw);
  endtask

  // Directed: extremes, hits, evictions with write-back, odd register values
  task automatic test_directed();
    send_access(ACT_READ, 32'h0000_0000);
    send_access(ACT_READ, 32'h0000_0004);
    send_access(ACT_WRITE, 32'hFFFF_FFFF);
    send_access(ACT_WRITE, 32'h0000_0040);
    send_access(ACT_READ, 32'h0000_0080);
    send_access(ACT_WRITE, 32'h0000_0000);
    send_access(ACT_READ, 32'h0000_0100);
    send_access(ACT_READ, 32'h0000_0200);
    send_access(ACT_READ, 32'hFFFF_FFF0);
    // clamped offset, wide index, zero and oversized way count
    set_geometry(3'd0, 3'd6, 3'd0);
    send_access(ACT_WRITE, 32'h0000_0010);
    send_access(ACT_WRITE, 32'h0000_1010);
    send_access(ACT_READ, 32'h0000_0010);
    set_geometry(3'd7, 3'd7, 3'd7);
    send_access(ACT_WRITE, 32'hAAAA_5555);
    send_access(ACT_READ, 32'h5555_AAAA);
    send_access(ACT_READ, 32'hAAAA_5555);
    // unknown register index is ignored
    write_reg(2'd3, 3'd1);
    send_access(ACT_WRITE, 32'h1234_5678);
  endtask

  // Random phase: mostly addresses from a small pool so sets thrash
  task automatic test_random(int unsigned count);
    logic [31:0] pool [8];
    logic [31:0] addr;
    for (int i = 0; i < 8; i++) pool[i] = $urandom();
    for (int unsigned n = 0; n < count; n++) begin
      if (n % 25 == 0)
        set_geometry(3'($urandom_range(7)), 3'($urandom_range(7)),
                     3'($urandom_range(7)));
      if ($urandom_range(9) < 7)
        addr = pool[$urandom_range(7)] ^ ($urandom_range(7) << $urandom_range(10));
      else
        addr = $urandom();
      send_access(1'($urandom_range(1)), addr);
    end
  endtask

  // Sender holds off until the block has drained
  task automatic test_drain_pause();
    send_access(ACT_WRITE, 32'h0000_0020);
    wait_drained();
    send_access(ACT_READ, 32'h0000_0020);
  endtask

  initial begin
    send_idle_pct = 7;
    recv_idle_pct = 87;
    sh_offset = 3'd4;
    sh_index = 3'd2;
    sh_ways = 3'd2;
    cnt_read = '0; cnt_write = '0; cnt_rhit = '0; cnt_whit = '0;
    cnt_rmiss = '0; cnt_wmiss = '0; cnt_wb = '0;
    for (int s = 0; s < NSETS; s++)
      for (int w = 0; w < NWAYS; w++) begin
        tag_line[s][w] = '0;
        tag_valid[s][w] = 1'b0;
        tag_dirty[s][w] = 1'b0;
        age_rank[s][w] = 0;
      end
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_random(150);
    test_drain_pause();
    send_idle_pct = 87;
    recv_idle_pct = 7;
    test_random(150);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(130);
    set_geometry(3'd5, 3'd0, 3'd4);
    test_random(20);

    wait_drained();
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
